// ===== hdl/aimg_pkg.sv =====
// Shared types, constants and register codes for the adaptive in-flight limit gate.
// Used by every module of the block; depends on nothing else.
package aimg_pkg;

   localparam int HIST_BINS = 4096;
   localparam int HIST_AW   = $clog2(HIST_BINS);
   localparam int MAX_BURST = 4096;

   localparam logic [12:0] RING_SIZE_RST     = 13'd256;
   localparam logic [31:0] TICK_INTERVAL_RST = 32'd200000;
   localparam logic [12:0] LIMIT_FLOOR_RST   = 13'd4;
   localparam logic [12:0] GROW_STEP_RST     = 13'd16;

   typedef enum logic [7:0] {
      REG_RING_SIZE     = 8'd0,
      REG_TICK_INTERVAL = 8'd1,
      REG_LIMIT_FLOOR   = 8'd2,
      REG_GROW_STEP     = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic [12:0] ring_size;
      logic [31:0] tick_interval;
      logic [12:0] limit_floor;
      logic [12:0] grow_step;
   } cfg_type;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [1:0]  pad;
      logic [11:0] bin_index;
      logic [15:0] freed;
      logic [12:0] accepted_prev;
      logic [12:0] requested;
      logic [63:0] now_time;
   } req_data_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic [31:0] bin_count;
      logic [63:0] poll_count;
      logic [63:0] inflight_sum;
      logic [15:0] max_inflight;
      logic [15:0] min_inflight;
      logic        tick_fired;
      logic [12:0] cur_limit;
      logic [15:0] inflight;
      logic [12:0] gated;
      logic [12:0] to_send;
   } rsp_data_type;

   // Scalar state seen by one request after its own updates.
   typedef struct packed {
      logic [15:0] inflight;
      logic [12:0] limit;
      logic        tick;
   } adapt_res_type;

   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
      logic [31:0]        data;
   } hist_wr_type;

endpackage

// ===== hdl/aimg_hist_mem.sv =====
// Histogram bin memory with one registered read port, one write port and a
// clearing pass after reset. Depends on aimg_pkg.
module aimg_hist_mem import aimg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [HIST_AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   input  hist_wr_type        wr,
   output logic               busy
);

   logic [31:0]        mem [HIST_BINS];
   logic [31:0]        rd_data_ff;
   logic [HIST_AW-1:0] clr_addr_ff;
   logic [HIST_AW-1:0] clr_addr_in;
   logic               clr_busy_ff;
   logic               clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == HIST_AW'(HIST_BINS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// ===== hdl/aimg_adapt.sv =====
// In-flight count, adaptive limit and tick timer, updated once per accepted poll.
// Depends on aimg_pkg.
module aimg_adapt import aimg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          poll_take,
   input  logic          is_poll,
   input  logic          demand,
   input  logic [63:0]   now_time,
   input  logic [12:0]   accepted_prev,
   input  logic [15:0]   freed,
   output adapt_res_type res
);

   logic [15:0] inflight_ff;
   logic [15:0] inflight_in;
   logic [12:0] limit_ff;
   logic [12:0] limit_in;
   logic [63:0] last_tick_ff;
   logic [63:0] last_tick_in;

   logic [16:0] add_sum;
   logic [15:0] add_sat;
   logic [15:0] drained;
   logic [63:0] elapsed;
   logic        tick;
   logic [13:0] grown;
   logic [12:0] grown_cap;
   logic [12:0] shrunk;
   logic [12:0] shrunk_floor;

   always_comb begin
      add_sum      = {1'b0, inflight_ff} + {4'b0, accepted_prev};
      add_sat      = add_sum[16] ? 16'hFFFF : add_sum[15:0];
      elapsed      = now_time - last_tick_ff;
      tick         = elapsed >= {32'b0, cfg.tick_interval};
      drained      = (add_sat > freed) ? (add_sat - freed) : 16'd0;
      grown        = {1'b0, limit_ff} + {1'b0, cfg.grow_step};
      grown_cap    = (grown < {1'b0, cfg.ring_size}) ? grown[12:0] : cfg.ring_size;
      shrunk       = (limit_ff > cfg.grow_step) ? (limit_ff - cfg.grow_step)
                                                : cfg.limit_floor;
      shrunk_floor = (shrunk < cfg.limit_floor) ? cfg.limit_floor : shrunk;

      inflight_in  = add_sat;
      limit_in     = limit_ff;
      last_tick_in = last_tick_ff;
      if (tick) begin
         inflight_in  = drained;
         last_tick_in = now_time;
         if (drained == 16'd0 && demand) begin
            limit_in = grown_cap;
         end else if (drained >= {3'b0, limit_ff} && demand) begin
            limit_in = shrunk_floor;
         end
      end

      if (is_poll) begin
         res.inflight = inflight_in;
         res.limit    = limit_in;
         res.tick     = tick;
      end else begin
         res.inflight = inflight_ff;
         res.limit    = limit_ff;
         res.tick     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= '0;
         limit_ff     <= LIMIT_FLOOR_RST;
         last_tick_ff <= '0;
      end else if (poll_take) begin
         inflight_ff  <= inflight_in;
         limit_ff     <= limit_in;
         last_tick_ff <= last_tick_in;
      end
   end

endmodule

// ===== hdl/adaptive_inflight_limit_gate_unit.sv =====
// Adaptive in-flight limit gate: an accepted request passes the second-stage registers and
// then the output register to rsp_tvalid. Throughput is one request per cycle while rsp_tready
// keeps the output moving; the histogram read-modify-write with forwarding and the update of
// in-flight count and limit at acceptance set that figure. Reset is synchronous; afterwards a
// clearing pass zeroes the 4096 histogram bins, during which req_tready stays low
// (configuration writes are still taken). Depends on aimg_pkg, aimg_adapt and aimg_hist_mem.
module adaptive_inflight_limit_gate_unit import aimg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // Request channel. tdata from bit 0: now_time 64, requested 13, accepted_prev 13,
   // freed 16, bin_index 12, two zero bits.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,
   // tuser: req_type (0 = poll and gate, 1 = histogram bin read).
   input  logic         req_tuser,
   // Response channel. tdata from bit 0: to_send 13, gated 13, inflight 16, cur_limit 13,
   // tick_fired 1, min_inflight 16, max_inflight 16, inflight_sum 64, poll_count 64,
   // bin_count 32.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [247:0] rsp_tdata,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_size     <= RING_SIZE_RST;
         cfg_ff.tick_interval <= TICK_INTERVAL_RST;
         cfg_ff.limit_floor   <= LIMIT_FLOOR_RST;
         cfg_ff.grow_step     <= GROW_STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RING_SIZE:     cfg_ff.ring_size     <= csr_data[12:0];
            REG_TICK_INTERVAL: cfg_ff.tick_interval <= csr_data;
            REG_LIMIT_FLOOR:   cfg_ff.limit_floor   <= csr_data[12:0];
            REG_GROW_STEP:     cfg_ff.grow_step     <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Front stage: a poll updates the scalar state at acceptance, and every request issues
   // the histogram read for the bin it will touch or report.
   req_data_type  req;
   logic          req_take;
   logic          is_poll;
   logic [12:0]   req_clamped;
   adapt_res_type adapt_res;
   logic          clr_busy;
   logic [15:0]   rd_key;
   logic          rd_ok;
   logic [HIST_AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   assign req     = req_data_type'(req_tdata);
   assign is_poll = !req_tuser;
   assign req_clamped = (req.requested > 13'(MAX_BURST)) ? 13'(MAX_BURST) : req.requested;

   aimg_adapt u_adapt (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .poll_take     (req_take && is_poll),
      .is_poll       (is_poll),
      .demand        (req_clamped != 13'd0),
      .now_time      (req.now_time),
      .accepted_prev (req.accepted_prev),
      .freed         (req.freed),
      .res           (adapt_res)
   );

   // A poll bins its own in-flight value; a read looks up the requested bin.
   assign rd_key  = is_poll ? adapt_res.inflight : {4'b0, req.bin_index};
   assign rd_ok   = {1'b0, rd_key} < 17'(HIST_BINS);
   assign rd_addr = rd_key[HIST_AW-1:0];

   // Second stage registers.
   logic               s1_valid_ff;
   logic               s1_poll_ff;
   adapt_res_type      s1_res_ff;
   logic [12:0]        s1_req_ff;
   logic               s1_bin_ok_ff;
   logic [HIST_AW-1:0] s1_addr_ff;
   logic               fwd_ff;
   logic [31:0]        fwd_data_ff;
   logic               s1_adv;
   hist_wr_type        hist_wr;

   // Output register.
   logic         rsp_valid_ff;
   rsp_data_type rsp_ff;
   rsp_data_type rsp_in;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_adv);
   assign req_take   = req_tvalid && req_tready;

   aimg_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (hist_wr),
      .busy    (clr_busy)
   );

   // Second stage: finish the bin update, compute the grant and the statistics.
   logic [15:0] min_ff;
   logic [15:0] max_ff;
   logic [63:0] sum_ff;
   logic [63:0] polls_ff;
   logic [15:0] min_in;
   logic [15:0] max_in;
   logic [63:0] sum_in;
   logic [63:0] polls_in;
   logic [31:0] bin_cur;
   logic [15:0] space;
   logic [12:0] room;
   logic [12:0] grant;

   always_comb begin
      // The write that retired in the cycle of this request's read is not yet
      // visible in the read data, so its value is taken from the bypass.
      bin_cur = fwd_ff ? fwd_data_ff : rd_data;

      hist_wr.en   = s1_adv && s1_poll_ff && s1_bin_ok_ff && (bin_cur != 32'hFFFF_FFFF);
      hist_wr.addr = s1_addr_ff;
      hist_wr.data = bin_cur + 32'd1;

      if (polls_ff == 64'd0) begin
         min_in = s1_res_ff.inflight;
         max_in = s1_res_ff.inflight;
      end else begin
         min_in = (s1_res_ff.inflight < min_ff) ? s1_res_ff.inflight : min_ff;
         max_in = (s1_res_ff.inflight > max_ff) ? s1_res_ff.inflight : max_ff;
      end
      sum_in   = sum_ff + {48'b0, s1_res_ff.inflight};
      polls_in = polls_ff + 64'd1;

      space = ({3'b0, s1_res_ff.limit} > s1_res_ff.inflight)
              ? ({3'b0, s1_res_ff.limit} - s1_res_ff.inflight) : 16'd0;
      room  = ({3'b0, cfg_ff.ring_size} < space) ? cfg_ff.ring_size : space[12:0];
      grant = (s1_req_ff < room) ? s1_req_ff : room;

      rsp_in.inflight   = s1_res_ff.inflight;
      rsp_in.cur_limit  = s1_res_ff.limit;
      rsp_in.tick_fired = s1_res_ff.tick;
      if (s1_poll_ff) begin
         rsp_in.to_send      = grant;
         rsp_in.gated        = s1_req_ff - grant;
         rsp_in.min_inflight = min_in;
         rsp_in.max_inflight = max_in;
         rsp_in.inflight_sum = sum_in;
         rsp_in.poll_count   = polls_in;
         rsp_in.bin_count    = 32'd0;
      end else begin
         rsp_in.to_send      = 13'd0;
         rsp_in.gated        = 13'd0;
         rsp_in.min_inflight = min_ff;
         rsp_in.max_inflight = max_ff;
         rsp_in.inflight_sum = sum_ff;
         rsp_in.poll_count   = polls_ff;
         rsp_in.bin_count    = s1_bin_ok_ff ? bin_cur : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         polls_ff     <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= hist_wr.en && (hist_wr.addr == rd_addr);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_adv && s1_poll_ff) begin
            min_ff   <= min_in;
            max_ff   <= max_in;
            sum_ff   <= sum_in;
            polls_ff <= polls_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_poll_ff   <= is_poll;
         s1_res_ff    <= adapt_res;
         s1_req_ff    <= req_clamped;
         s1_bin_ok_ff <= rd_ok;
         s1_addr_ff   <= rd_addr;
         fwd_data_ff  <= hist_wr.data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTH
   // No request may enter while the histogram is still being cleared.
   assert property (@(posedge clock) disable iff (reset) clr_busy |-> !req_take)
      else $error("request accepted during histogram clearing pass");

   // The bypass is only armed for a request that is waiting in the second stage.
   assert property (@(posedge clock) disable iff (reset) fwd_ff |-> s1_valid_ff)
      else $error("histogram bypass armed without a request in flight");

   // A grant never pushes the in-flight count past the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.to_send != 13'd0) |->
      ({1'b0, rsp_ff.inflight} + 17'(rsp_ff.to_send) <= 17'(rsp_ff.cur_limit)))
      else $error("grant exceeds remaining in-flight room");

   // Once a poll has been seen, the minimum never exceeds the maximum.
   assert property (@(posedge clock) disable iff (reset)
      (polls_ff != 64'd0) |-> (min_ff <= max_ff))
      else $error("in-flight minimum above maximum");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for adaptive_inflight_limit_gate_unit: a queued request driver,
// a stalling response monitor and a predictor of the gate, its adaptive limit and histogram.
// Depends on aimg_pkg and the RTL of the unit.
module testbench;
   import aimg_pkg::*;

   // An index past the register list; writes to it must leave every register alone.
   localparam logic [7:0] REG_UNMAPPED = 8'd4;

   typedef struct packed {
      logic         is_read;
      req_data_type data;
   } gate_req_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [247:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   adaptive_inflight_limit_gate_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow of the registers and the gate state as the predictor sees them.
   cfg_type      regs;
   logic [15:0]  inflight_cnt;
   logic [12:0]  limit_cur;
   logic [63:0]  last_tick_at;
   logic [15:0]  min_infl;
   logic [15:0]  max_infl;
   logic [63:0]  infl_total;
   logic [63:0]  polls_done;
   logic [31:0]  hist_cnt [HIST_BINS];

   gate_req_type pending_reqs [$];
   rsp_data_type outcomes_due [$];
   gate_req_type cur_req;
   logic         req_busy = 1'b0;
   logic [63:0]  stim_now;

   int n_errors = 0;
   int reqs_queued = 0;
   int reqs_accepted = 0;
   int n_reads = 0;
   int n_polls = 0;
   int n_ticks = 0;
   int n_compared = 0;
   int n_settings = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Works out the response to one request and advances the shadow state.
   function automatic rsp_data_type gate_outcome(input gate_req_type r);
      rsp_data_type o;
      logic [12:0]  want;
      logic [16:0]  total;
      logic [13:0]  grown;
      logic [15:0]  space;
      logic [15:0]  room;
      o = '0;
      if (r.is_read) begin
         o.bin_count = hist_cnt[r.data.bin_index];
      end else begin
         want = (r.data.requested > 13'(MAX_BURST)) ? 13'(MAX_BURST) : r.data.requested;
         total = inflight_cnt + r.data.accepted_prev;
         inflight_cnt = (total > 17'h0FFFF) ? 16'hFFFF : total[15:0];
         // The distance is taken modulo 2^64, so a clock that wrapped still ticks.
         if (r.data.now_time - last_tick_at >= 64'(regs.tick_interval)) begin
            o.tick_fired = 1'b1;
            inflight_cnt = (inflight_cnt > r.data.freed) ? inflight_cnt - r.data.freed
                                                         : 16'd0;
            if (inflight_cnt == 16'd0 && want != 13'd0) begin
               // Growth ignores the floor; only the ring depth caps it.
               grown = limit_cur + regs.grow_step;
               limit_cur = (grown < 14'(regs.ring_size)) ? grown[12:0] : regs.ring_size;
            end else if (inflight_cnt >= 16'(limit_cur) && want != 13'd0) begin
               limit_cur = (limit_cur > regs.grow_step) ? limit_cur - regs.grow_step
                                                        : regs.limit_floor;
               if (limit_cur < regs.limit_floor) begin
                  limit_cur = regs.limit_floor;
               end
            end
            last_tick_at = r.data.now_time;
         end
         if (inflight_cnt < 16'(HIST_BINS) &&
             hist_cnt[inflight_cnt[11:0]] != 32'hFFFF_FFFF) begin
            hist_cnt[inflight_cnt[11:0]] = hist_cnt[inflight_cnt[11:0]] + 32'd1;
         end
         if (polls_done == 64'd0) begin
            min_infl = inflight_cnt;
            max_infl = inflight_cnt;
         end else begin
            if (inflight_cnt < min_infl) begin
               min_infl = inflight_cnt;
            end
            if (inflight_cnt > max_infl) begin
               max_infl = inflight_cnt;
            end
         end
         infl_total = infl_total + 64'(inflight_cnt);
         polls_done = polls_done + 64'd1;
         space = (16'(limit_cur) > inflight_cnt) ? 16'(limit_cur) - inflight_cnt : 16'd0;
         room = (16'(regs.ring_size) < space) ? 16'(regs.ring_size) : space;
         o.to_send = (16'(want) < room) ? want : room[12:0];
         o.gated = want - o.to_send;
      end
      o.inflight = inflight_cnt;
      o.cur_limit = limit_cur;
      o.min_inflight = min_infl;
      o.max_inflight = max_infl;
      o.inflight_sum = infl_total;
      o.poll_count = polls_done;
      return o;
   endfunction

   // Random request. The time base often steps by about one tick interval so that ticks fire
   // often, otherwise by up to half an interval, with wraps, backward steps and wild jumps mixed in.
   function automatic gate_req_type random_req();
      gate_req_type r;
      logic [63:0]  hop;
      r = '0;
      hop = 64'(regs.tick_interval);
      r.is_read = ($urandom_range(0, 99) < 15);
      case ($urandom_range(0, 19))
         0:             stim_now = {$urandom, $urandom};
         1:             stim_now = stim_now - 64'($urandom_range(1, 1000));
         2:             stim_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         3, 4, 5, 6, 7, 8: stim_now = stim_now + hop + 64'($urandom_range(0, 3));
         default:       stim_now = stim_now + 64'($urandom) % (hop / 64'd2 + 64'd1);
      endcase
      r.data.now_time = stim_now;
      case ($urandom_range(0, 19))
         0, 1, 2:    r.data.requested = 13'd0;
         3, 4, 5:    r.data.requested = 13'($urandom_range(65, 4096));
         6, 7:       r.data.requested = 13'(MAX_BURST);
         8, 9:       r.data.requested = 13'($urandom_range(4097, 8191));
         default:    r.data.requested = 13'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 49))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: r.data.accepted_prev = 13'd0;
         10, 11, 12, 13, 14:           r.data.accepted_prev = 13'($urandom_range(33, 4096));
         15, 16:                       r.data.accepted_prev = 13'($urandom_range(4097, 8191));
         default:                      r.data.accepted_prev = 13'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2:    r.data.freed = 16'd0;
         3, 4, 5, 6: r.data.freed = 16'($urandom_range(65, 4096));
         7:          r.data.freed = 16'hFFFF;
         8:          r.data.freed = 16'($urandom_range(4097, 65535));
         default:    r.data.freed = 16'($urandom_range(1, 64));
      endcase
      r.data.bin_index = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 300))
                                                    : 12'($urandom);
      return r;
   endfunction

   task automatic queue_req(input gate_req_type r);
      pending_reqs.push_back(r);
      reqs_queued++;
      if (r.is_read) begin
         n_reads++;
      end else begin
         n_polls++;
      end
   endtask

   task automatic queue_directed(input logic is_read, input logic [63:0] now_v,
                                 input logic [12:0] want_v, input logic [12:0] acc_v,
                                 input logic [15:0] freed_v, input logic [11:0] bin_v);
      gate_req_type r;
      r = '0;
      r.is_read = is_read;
      r.data.now_time = now_v;
      r.data.requested = want_v;
      r.data.accepted_prev = acc_v;
      r.data.freed = freed_v;
      r.data.bin_index = bin_v;
      queue_req(r);
   endtask

   // Holds until every queued request was taken and answered.
   task automatic wait_drained();
      while (reqs_accepted != reqs_queued || outcomes_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_RING_SIZE) begin
         regs.ring_size = value[12:0];
      end else if (idx == REG_TICK_INTERVAL) begin
         regs.tick_interval = value;
      end else if (idx == REG_LIMIT_FLOOR) begin
         regs.limit_floor = value[12:0];
      end else if (idx == REG_GROW_STEP) begin
         regs.grow_step = value[12:0];
      end
   endtask

   // One setting of all four registers, then a batch of random requests under it.
   // The upper mask fills the unused bits of the 13-bit registers.
   task automatic run_phase(input logic [12:0] ring, input logic [31:0] interval,
                            input logic [12:0] floor_v, input logic [12:0] step_v,
                            input logic [31:0] upper, input int count);
      wait_drained();
      write_reg(REG_RING_SIZE, upper | 32'(ring));
      write_reg(REG_TICK_INTERVAL, interval);
      write_reg(REG_LIMIT_FLOOR, upper | 32'(floor_v));
      write_reg(REG_GROW_STEP, upper | 32'(step_v));
      n_settings++;
      repeat (count) begin
         queue_req(random_req());
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   task automatic check_rsp(input rsp_data_type got);
      rsp_data_type want;
      if (outcomes_due.size() == 0) begin
         $error("response with no request outstanding: tdata %h", got);
         n_errors++;
      end else begin
         want = outcomes_due.pop_front();
         n_compared++;
         if (want.tick_fired) begin
            n_ticks++;
         end
         check_field("to_send", want.to_send, got.to_send);
         check_field("gated", want.gated, got.gated);
         check_field("inflight", want.inflight, got.inflight);
         check_field("cur_limit", want.cur_limit, got.cur_limit);
         check_field("tick_fired", want.tick_fired, got.tick_fired);
         check_field("min_inflight", want.min_inflight, got.min_inflight);
         check_field("max_inflight", want.max_inflight, got.max_inflight);
         check_field("inflight_sum", want.inflight_sum, got.inflight_sum);
         check_field("poll_count", want.poll_count, got.poll_count);
         check_field("bin_count", want.bin_count, got.bin_count);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps. A request is
   // predicted at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcomes_due.push_back(gate_outcome(cur_req));
            reqs_accepted++;
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_busy = 1'b1;
               req_tdata <= cur_req.data;
               req_tuser <= cur_req.is_read;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  case ($urandom_range(0, 9))
                     0, 1, 2: gap_left = 0;
                     9:       gap_left = $urandom_range(10, 30);
                     default: gap_left = $urandom_range(1, 5);
                  endcase
               end
            end
         end
         req_tvalid <= req_busy;
      end
   end

   // Response monitor. The ready pattern switches between free flow, coin flips,
   // a fixed two-in-three rhythm and heavy back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_rsp(rsp_data_type'(rsp_tdata));
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (stall_left % 3) != 0;
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      logic [31:0] rnd_interval;
      regs = '{ring_size: RING_SIZE_RST, tick_interval: TICK_INTERVAL_RST,
               limit_floor: LIMIT_FLOOR_RST, grow_step: GROW_STEP_RST};
      inflight_cnt = '0;
      limit_cur = LIMIT_FLOOR_RST;
      last_tick_at = '0;
      min_infl = '0;
      max_infl = '0;
      infl_total = '0;
      polls_done = '0;
      foreach (hist_cnt[i]) begin
         hist_cnt[i] = '0;
      end
      stim_now = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings. Reads of a cleared store first.
      queue_directed(1'b1, 64'd0, 13'd0, 13'd0, 16'd0, 12'd0);
      queue_directed(1'b1, 64'd0, 13'd0, 13'd0, 16'd0, 12'd4095);
      // First poll seeds min and max; no tick at time zero.
      queue_directed(1'b0, 64'd0, 13'd0, 13'd0, 16'd0, 12'd0);
      // Tick exactly one interval later with an empty queue and demand: growth.
      queue_directed(1'b0, 64'd200000, 13'd10, 13'd0, 16'd0, 12'd0);
      // Oversized request is clamped to the largest burst.
      queue_directed(1'b0, 64'd200001, 13'd8191, 13'd10, 16'd0, 12'd0);
      // Large acceptance past the limit, then a tick: shrink down to the floor.
      queue_directed(1'b0, 64'd400001, 13'd4096, 13'd8191, 16'd0, 12'd0);
      // Keep adding until the in-flight count saturates.
      for (int i = 0; i < 7; i++) begin
         queue_directed(1'b0, 64'd400002 + 64'(i), 13'd1, 13'd8191, 16'd0, 12'd0);
      end
      // A tick frees exactly what is in flight: the count drops to zero.
      queue_directed(1'b0, 64'd600001, 13'd3, 13'd0, 16'hFFFF, 12'd0);
      queue_directed(1'b0, 64'd600002, 13'd0, 13'd0, 16'd0, 12'd0);
      // Tick with no demand at the top of the time range, then a wrapped clock.
      queue_directed(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0, 13'd0, 16'd0, 12'd0);
      queue_directed(1'b0, 64'd5, 13'd2, 13'd3, 16'd1, 12'd0);
      queue_directed(1'b0, 64'd199999, 13'd7, 13'd6, 16'd2, 12'd0);
      queue_directed(1'b0, 64'h8000_0000_0000_0000, 13'd4095, 13'd4096, 16'd4096, 12'hFFF);
      // Reads of bins 0 and 7 (filled) and 4095 (empty); junk in other fields must not matter.
      queue_directed(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 13'd8191, 13'd8191, 16'hFFFF, 12'd0);
      queue_directed(1'b1, 64'd0, 13'd0, 13'd0, 16'd0, 12'd7);
      queue_directed(1'b1, 64'd0, 13'd1, 13'd1, 16'd1, 12'd4095);

      // A write to an unmapped index has no effect.
      wait_drained();
      write_reg(REG_UNMAPPED, 32'h0000_0001);

      run_phase(13'd4096, 32'd1, 13'd1, 13'd1, 32'h0, 200);
      // A zero interval ticks on every poll; the step exceeds any limit.
      run_phase(13'd1, 32'd0, 13'd1, 13'd4096, 32'h0, 150);
      // Widest interval and largest floor; the floor write does not reseed the limit.
      run_phase(13'd4096, 32'hFFFF_FFFF, 13'd4096, 13'd4096, 32'h0, 150);
      // Floor above ring depth: growth settles below the floor.
      run_phase(13'd64, 32'd8, 13'd200, 13'd24, 32'h0, 150);
      run_phase(13'd300, 32'd40, 13'd8, 13'd5, 32'hFFFF_E000, 200);
      repeat (3) begin
         rnd_interval = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 200);
         run_phase(13'($urandom_range(1, 4096)), rnd_interval,
                   13'($urandom_range(1, 512)), 13'($urandom_range(1, 300)), 32'h0, 170);
      end

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Covered %0d polls and %0d bin reads under %0d register settings.",
               n_polls, n_reads, n_settings + 1);
      $display("%0d responses compared, %0d limit ticks, %0d mismatches.",
               n_compared, n_ticks, n_errors);
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("Timeout with %0d requests unanswered.", reqs_queued - n_compared);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
